// ----- rtl/rcfd_pkg.sv -----
// rcfd_pkg: shared types, codes and decode tables of the radio command frame decoder
`default_nettype none

package rcfd_pkg;

    localparam int FIXED_BUF_BYTES = 4;
    localparam int BUF_IDX_BITS    = $clog2(FIXED_BUF_BYTES);

    typedef enum logic [1:0] {
        CMD_DATA  = 2'd0,
        CMD_END   = 2'd1,
        CMD_START = 2'd2,
        CMD_IDLE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_FIXED  = 2'd1,
        PH_STREAM = 2'd2,
        PH_ABORT  = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_FREQ        = 4'd1,
        EV_BW          = 4'd2,
        EV_TXPOWER     = 4'd3,
        EV_SF          = 4'd4,
        EV_CR          = 4'd5,
        EV_RADIO_STATE = 4'd6,
        EV_LOCK        = 4'd7,
        EV_DETECT      = 4'd8,
        EV_LEAVE       = 4'd9,
        EV_READY       = 4'd10,
        EV_SSTART      = 4'd11,
        EV_SBYTE       = 4'd12,
        EV_SEND        = 4'd13,
        EV_ERROR       = 4'd14
    } event_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_BADARG  = 3'd2,
        ST_BADLEN  = 3'd3,
        ST_ABORTED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        LEN_ZERO    = 3'd0,
        LEN_ONE     = 3'd1,
        LEN_FOUR    = 3'd4,
        LEN_STREAM  = 3'd6,
        LEN_UNKNOWN = 3'd7
    } len_t;

    localparam logic [3:0] OP_STREAM      = 4'h0;
    localparam logic [3:0] OP_FREQ        = 4'h1;
    localparam logic [3:0] OP_BW          = 4'h2;
    localparam logic [3:0] OP_TXPOWER     = 4'h3;
    localparam logic [3:0] OP_SF          = 4'h4;
    localparam logic [3:0] OP_CR          = 4'h5;
    localparam logic [3:0] OP_RADIO_STATE = 4'h6;
    localparam logic [3:0] OP_LOCK        = 4'h7;
    localparam logic [3:0] OP_DETECT      = 4'h8;
    localparam logic [3:0] OP_LEAVE       = 4'hA;
    localparam logic [3:0] OP_READY       = 4'hF;

    localparam logic [7:0] RADIO_OFF   = 8'h00;
    localparam logic [7:0] RADIO_ON    = 8'h01;
    localparam logic [7:0] RADIO_QUERY = 8'hFF;
    localparam logic [7:0] DETECT_KEY  = 8'h73;

    typedef struct packed {
        event_t        event_res;
        logic [3:0]    port_id;
        logic [31:0]   arg_value;
        logic [3:0]    error_opcode;
        logic [15:0]   error_position;
        status_t       error_code;
        status_t       ret_status;
    } result_t;

    function automatic len_t opcode_len(input logic [3:0] op);
        len_t len;
        unique case (op)
            OP_STREAM:                              len = LEN_STREAM;
            OP_FREQ, OP_BW:                         len = LEN_FOUR;
            OP_TXPOWER, OP_SF, OP_CR, OP_RADIO_STATE,
            OP_LOCK, OP_DETECT, OP_LEAVE:           len = LEN_ONE;
            OP_READY:                               len = LEN_ZERO;
            default:                                len = LEN_UNKNOWN;
        endcase
        return len;
    endfunction

    function automatic event_t opcode_event(input logic [3:0] op);
        event_t ev;
        unique case (op)
            OP_FREQ:        ev = EV_FREQ;
            OP_BW:          ev = EV_BW;
            OP_TXPOWER:     ev = EV_TXPOWER;
            OP_SF:          ev = EV_SF;
            OP_CR:          ev = EV_CR;
            OP_RADIO_STATE: ev = EV_RADIO_STATE;
            OP_LOCK:        ev = EV_LOCK;
            OP_DETECT:      ev = EV_DETECT;
            OP_LEAVE:       ev = EV_LEAVE;
            OP_READY:       ev = EV_READY;
            default:        ev = EV_NONE;
        endcase
        return ev;
    endfunction

    function automatic result_t make_event(input event_t ev, input logic [3:0] port,
                                           input logic [31:0] arg);
        result_t r;
        r = '{event_res: ev, port_id: port, arg_value: arg, error_opcode: 4'd0,
              error_position: 16'd0, error_code: ST_OK, ret_status: ST_OK};
        return r;
    endfunction

    function automatic result_t make_error(input logic [3:0] port, input logic [3:0] op,
                                           input logic [15:0] pos, input status_t code);
        result_t r;
        r = '{event_res: EV_ERROR, port_id: port, arg_value: 32'd0, error_opcode: op,
              error_position: pos, error_code: code, ret_status: code};
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/radio_command_frame_decoder.sv -----
// radio_command_frame_decoder: top level, frame parser with a two-entry output buffer
//
//  channel | direction | handshake          | fields
//  in      | input     | in_valid/in_stall  | cmd, data_byte, sink_fault
//  out     | output    | out_valid/out_stall| event_res, port_id, arg_value, error_opcode,
//          |           |                    | error_position, error_code, ret_status
//
// one result word per input word; the result is registered in the output register before out_valid
// a new word is taken every cycle while in_stall is low; the parse is a single pass of decode logic
// reset is asynchronous; the parser returns to waiting for a header, no clearing pass
// an output stall is absorbed by a skid entry; in_stall rises once that entry is full
`default_nettype none

module radio_command_frame_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    cmd,
    input  wire logic [7:0]    data_byte,
    input  wire logic          sink_fault,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [3:0]         event_res,
    output logic [3:0]         port_id,
    output logic [31:0]        arg_value,
    output logic [3:0]         error_opcode,
    output logic [15:0]        error_position,
    output logic [2:0]         error_code,
    output logic [2:0]         ret_status
);

    logic                  in_accept;
    rcfd_pkg::result_t     core_res;

    logic                  out_valid_reg, out_valid_next;
    rcfd_pkg::result_t     out_res_reg, out_res_next;
    logic                  skid_valid_reg, skid_valid_next;
    rcfd_pkg::result_t     skid_res_reg, skid_res_next;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;

    rcfd_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .sink_fault (sink_fault),
        .res        (core_res)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_accept;
                out_res_next   = core_res;
            end
        end
        else if (in_accept)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = core_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = out_res_reg.event_res;
    assign port_id        = out_res_reg.port_id;
    assign arg_value      = out_res_reg.arg_value;
    assign error_opcode   = out_res_reg.error_opcode;
    assign error_position = out_res_reg.error_position;
    assign error_code     = out_res_reg.error_code;
    assign ret_status     = out_res_reg.ret_status;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid filled without a stalled output");

    a_error_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.event_res == rcfd_pkg::EV_ERROR)
            |-> (out_res_reg.error_code != rcfd_pkg::ST_OK
                 && out_res_reg.ret_status == out_res_reg.error_code))
        else $error("error word with inconsistent status");

    a_plain_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.event_res != rcfd_pkg::EV_ERROR)
            |-> (out_res_reg.error_code == rcfd_pkg::ST_OK
                 && out_res_reg.error_position == 16'd0
                 && out_res_reg.error_opcode == 4'd0))
        else $error("error fields set on a non-error word");

endmodule

`default_nettype wire

// ----- rtl/rcfd_core.sv -----
// rcfd_core: frame parser state and per-word result decode
`default_nettype none

module rcfd_core #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [1:0]          cmd,
    input  wire logic [7:0]          data_byte,
    input  wire logic                sink_fault,
    output rcfd_pkg::result_t        res
);

    rcfd_pkg::phase_t          phase_reg, phase_next;
    logic [3:0]                port_reg, port_next;
    logic [3:0]                opcode_reg, opcode_next;
    logic [2:0]                exp_len_reg, exp_len_next;
    logic [COUNT_BITS-1:0]     count_reg, count_next;
    logic [7:0]                payload_reg [rcfd_pkg::FIXED_BUF_BYTES];

    logic                      pay_wr;
    logic [COUNT_BITS-1:0]     count_sat;
    logic [15:0]               err_pos;
    logic [3:0]                hdr_port;
    logic [3:0]                hdr_opcode;
    rcfd_pkg::len_t            hdr_len;
    logic [31:0]               fixed_value;
    logic                      bad_arg;

    generate
        if (COUNT_BITS > 16) begin : g_pos_sat
            assign err_pos = (|count_reg[COUNT_BITS-1:16]) ? 16'hFFFF : count_reg[15:0];
        end else begin : g_pos_ext
            assign err_pos = 16'(count_reg);
        end
    endgenerate

    assign count_sat  = (count_reg == '1) ? count_reg : count_reg + COUNT_BITS'(1);
    assign hdr_port   = data_byte[7:4];
    assign hdr_opcode = data_byte[3:0];
    assign hdr_len    = rcfd_pkg::opcode_len(hdr_opcode);

    // big-endian payload assembly
    always_comb
    begin
        if (exp_len_reg == rcfd_pkg::LEN_FOUR)
            fixed_value = {payload_reg[0], payload_reg[1], payload_reg[2], payload_reg[3]};
        else if (exp_len_reg == rcfd_pkg::LEN_ONE)
            fixed_value = {24'd0, payload_reg[0]};
        else
            fixed_value = 32'd0;
    end

    assign bad_arg = ((opcode_reg == rcfd_pkg::OP_RADIO_STATE)
                      && (fixed_value != 32'(rcfd_pkg::RADIO_OFF))
                      && (fixed_value != 32'(rcfd_pkg::RADIO_ON))
                      && (fixed_value != 32'(rcfd_pkg::RADIO_QUERY)))
                  || ((opcode_reg == rcfd_pkg::OP_DETECT)
                      && (fixed_value != 32'(rcfd_pkg::DETECT_KEY)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= rcfd_pkg::PH_WAIT;
            port_reg    <= '0;
            opcode_reg  <= '0;
            exp_len_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            port_reg    <= port_next;
            opcode_reg  <= opcode_next;
            exp_len_reg <= exp_len_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_wr)
            payload_reg[count_reg[rcfd_pkg::BUF_IDX_BITS-1:0]] <= data_byte;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        port_next    = port_reg;
        opcode_next  = opcode_reg;
        exp_len_next = exp_len_reg;
        count_next   = count_reg;
        pay_wr       = 1'b0;
        res          = rcfd_pkg::make_event(rcfd_pkg::EV_NONE, 4'd0, 32'd0);

        if (accept)
        begin
            unique case (rcfd_pkg::cmd_t'(cmd))
                rcfd_pkg::CMD_START:
                begin
                    phase_next = rcfd_pkg::PH_WAIT;
                    count_next = '0;
                end
                rcfd_pkg::CMD_IDLE:
                begin
                    phase_next = phase_reg;
                end
                rcfd_pkg::CMD_DATA:
                begin
                    unique case (phase_reg)
                        rcfd_pkg::PH_WAIT:
                        begin
                            port_next   = hdr_port;
                            opcode_next = hdr_opcode;
                            count_next  = '0;
                            if (hdr_len == rcfd_pkg::LEN_UNKNOWN)
                            begin
                                phase_next = rcfd_pkg::PH_ABORT;
                                res = rcfd_pkg::make_error(hdr_port, hdr_opcode, 16'd0,
                                                           rcfd_pkg::ST_UNKNOWN);
                            end
                            else if (hdr_len == rcfd_pkg::LEN_STREAM)
                            begin
                                phase_next = rcfd_pkg::PH_STREAM;
                                res = rcfd_pkg::make_event(rcfd_pkg::EV_SSTART, hdr_port,
                                                           32'd0);
                            end
                            else
                            begin
                                exp_len_next = hdr_len;
                                phase_next   = rcfd_pkg::PH_FIXED;
                            end
                        end
                        rcfd_pkg::PH_FIXED:
                        begin
                            if (count_reg < COUNT_BITS'(rcfd_pkg::FIXED_BUF_BYTES))
                            begin
                                pay_wr     = 1'b1;
                                count_next = count_sat;
                            end
                            else
                            begin
                                phase_next = rcfd_pkg::PH_ABORT;
                                res = rcfd_pkg::make_error(port_reg, opcode_reg, err_pos,
                                                           rcfd_pkg::ST_BADLEN);
                            end
                        end
                        rcfd_pkg::PH_STREAM:
                        begin
                            if (sink_fault)
                            begin
                                phase_next = rcfd_pkg::PH_ABORT;
                                res = rcfd_pkg::make_error(port_reg, opcode_reg, err_pos,
                                                           rcfd_pkg::ST_ABORTED);
                            end
                            else
                            begin
                                count_next = count_sat;
                                res = rcfd_pkg::make_event(rcfd_pkg::EV_SBYTE, port_reg,
                                                           {24'd0, data_byte});
                            end
                        end
                        rcfd_pkg::PH_ABORT:
                        begin
                            phase_next = rcfd_pkg::PH_ABORT;
                        end
                    endcase
                end
                rcfd_pkg::CMD_END:
                begin
                    unique case (phase_reg)
                        rcfd_pkg::PH_FIXED:
                        begin
                            if (count_reg != COUNT_BITS'(exp_len_reg))
                                res = rcfd_pkg::make_error(port_reg, opcode_reg, err_pos,
                                                           rcfd_pkg::ST_BADLEN);
                            else if (bad_arg)
                                res = rcfd_pkg::make_error(port_reg, opcode_reg, err_pos,
                                                           rcfd_pkg::ST_BADARG);
                            else
                                res = rcfd_pkg::make_event(
                                    rcfd_pkg::opcode_event(opcode_reg), port_reg,
                                    fixed_value);
                            phase_next = rcfd_pkg::PH_WAIT;
                            count_next = '0;
                        end
                        rcfd_pkg::PH_STREAM:
                        begin
                            if (sink_fault)
                            begin
                                phase_next = rcfd_pkg::PH_ABORT;
                                res = rcfd_pkg::make_error(port_reg, opcode_reg, err_pos,
                                                           rcfd_pkg::ST_ABORTED);
                            end
                            else
                            begin
                                phase_next = rcfd_pkg::PH_WAIT;
                                count_next = '0;
                                res = rcfd_pkg::make_event(rcfd_pkg::EV_SEND, port_reg,
                                                           32'd0);
                            end
                        end
                        rcfd_pkg::PH_WAIT, rcfd_pkg::PH_ABORT:
                        begin
                            phase_next     = rcfd_pkg::PH_WAIT;
                            count_next     = '0;
                            res.ret_status = rcfd_pkg::ST_ABORTED;
                        end
                    endcase
                end
            endcase
        end
    end

    // fixed payload never counts past the buffer
    a_fixed_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rcfd_pkg::PH_FIXED)
            |-> (count_reg <= COUNT_BITS'(rcfd_pkg::FIXED_BUF_BYTES)))
        else $error("fixed payload count beyond buffer");

    a_fixed_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rcfd_pkg::PH_FIXED)
            |-> (exp_len_reg == rcfd_pkg::LEN_ZERO || exp_len_reg == rcfd_pkg::LEN_ONE
                 || exp_len_reg == rcfd_pkg::LEN_FOUR))
        else $error("fixed frame with non-fixed length");

    a_wait_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rcfd_pkg::PH_WAIT) |-> (count_reg == '0))
        else $error("byte count not cleared while waiting for header");

endmodule

`default_nettype wire
